// ----- rtl/assert_macros.svh -----
// Concurrent assertion helpers; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

// ----- rtl/b32d_pkg.sv -----
package b32d_pkg;

	localparam int CHAR_W = 8;
	localparam int SYM_W  = 5;
	localparam int POS_W  = 3;

	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [CHAR_W-1:0] CASE_FOLD    = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_TWO     = 8'h32;
	localparam logic [CHAR_W-1:0] CHAR_SEVEN   = 8'h37;
	localparam logic [SYM_W-1:0]  DIGIT_BASE   = 5'h1a;
	localparam logic [POS_W-1:0]  SYM_ADVANCE  = 3'd5;
	localparam logic [POS_W-1:0]  POS_FILL     = 3'd3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last_char;
	} char_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       end_of_message;
	} res_word_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] value;
	} sym_t;

	typedef struct packed {
		logic      emit;
		res_word_t word;
	} pack_res_t;

endpackage

// ----- rtl/b32d_sym.sv -----
module b32d_sym
	import b32d_pkg::*;
(
	input  logic [CHAR_W-1:0] in_char,
	output sym_t              sym
);

	logic [CHAR_W-1:0] upper;
	logic [CHAR_W-1:0] off_a;
	logic [CHAR_W-1:0] off_2;

	always_comb begin
		if (in_char >= CHAR_LOWER_A && in_char <= CHAR_LOWER_Z) begin
			upper = in_char - CASE_FOLD;
		end else begin
			upper = in_char;
		end
		off_a = upper - CHAR_UPPER_A;
		off_2 = upper - CHAR_TWO;
		priority if (upper >= CHAR_UPPER_A && upper <= CHAR_UPPER_Z) begin
			sym.valid = 1'b1;
			sym.value = off_a[SYM_W-1:0];
		end else if (upper >= CHAR_TWO && upper <= CHAR_SEVEN) begin
			sym.valid = 1'b1;
			sym.value = off_2[SYM_W-1:0] + DIGIT_BASE;
		end else begin
			sym.valid = 1'b0;
			sym.value = '0;
		end
	end

endmodule

// ----- rtl/b32d_pack.sv -----
module b32d_pack
	import b32d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  sym_t      sym,
	input  logic      last_char,
	output pack_res_t res
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       acc_q;
	logic [15:0]      merged;
	logic             done;

	// symbol lands at bit offset pos from the MSB; upper half is the byte
	assign merged = {acc_q, 8'h00} | ({sym.value, 11'b0} >> pos_q);
	assign done   = sym.valid && (pos_q >= POS_FILL);

	always_comb begin
		res.emit                = done || last_char;
		res.word.out_byte       = done ? merged[15:8] : 8'h00;
		res.word.byte_valid     = done;
		res.word.end_of_message = last_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
		end else if (step) begin
			if (last_char) begin
				pos_q <= '0;
				acc_q <= '0;
			end else if (sym.valid) begin
				pos_q <= pos_q + SYM_ADVANCE;
				acc_q <= done ? merged[7:0] : merged[15:8];
			end
		end
	end

endmodule

// ----- rtl/base32_decoder_top.sv -----
// channel | direction | payload     | handshake
// char    | into      | char_word_t | char_valid / char_stall
// res     | out of    | res_word_t  | res_valid / res_stall
//
// One character word per cycle unless stalled; input stage, then result register.
// Symbol lookup and packing sit between the input stage and result register.
// Reset clears both valid flags, the bit position and the partial byte.
// A stalled result holds the input stage; char_stall rises only then.
module base32_decoder_top
	import b32d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_word_t char_word,
	output logic       res_valid,
	input  logic       res_stall,
	output res_word_t  res_word
);

	logic       valid_s1;
	char_word_t word_s1;
	logic       res_valid_q;
	res_word_t  res_word_q;
	logic       out_free;
	logic       adv;
	sym_t       sym;
	pack_res_t  pres;

	assign out_free   = !res_valid_q || !res_stall;
	assign adv        = valid_s1 && out_free;
	assign char_stall = valid_s1 && !out_free;
	assign res_valid  = res_valid_q;
	assign res_word   = res_word_q;

	b32d_sym u_sym (
		.in_char (word_s1.in_char),
		.sym     (sym)
	);

	b32d_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.sym       (sym),
		.last_char (word_s1.last_char),
		.res       (pres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (!char_stall) begin
				valid_s1 <= char_valid;
			end
			if (out_free) begin
				res_valid_q <= adv && pres.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			word_s1 <= char_word;
		end
		if (adv && pres.emit) begin
			res_word_q <= pres.word;
		end
	end

endmodule

// ----- rtl/b32d_chk.sv -----
`include "assert_macros.svh"

module b32d_chk
	import b32d_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       char_valid,
	input logic       char_stall,
	input char_word_t char_word,
	input logic       res_valid,
	input logic       res_stall,
	input res_word_t  res_word
);

	`CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_word))
	`CHK_NEXT(a_char_hold, char_valid && char_stall, char_valid && $stable(char_word))
	`CHK_NOW(a_empty_is_eom, res_valid && !res_word.byte_valid, res_word.end_of_message)
	`CHK_NOW(a_empty_zero, res_valid && !res_word.byte_valid, res_word.out_byte == 8'h00)
	`CHK_NOW(a_stall_cause, char_stall, res_valid && res_stall)

endmodule

bind base32_decoder_top b32d_chk u_b32d_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_word  (char_word),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_word   (res_word)
);

// ----- tb/testbench.sv -----
module testbench;
	import b32d_pkg::*;

	localparam int N_ITEMS     = 1850;
	localparam int LONG_HOLD   = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int N_ROWS      = 25;

	localparam logic TYPED = 1'b1;
	localparam logic PRED  = 1'b0;
	localparam res_word_t NO_RES = '0;

	localparam logic [7:0] SKIP_CHARS [5] = '{"=", "0", "1", "8", "9"};

	typedef struct packed {
		logic [7:0] ch;
		logic       last_flag;
		logic       typed;
		res_word_t  want;
	} row_t;

	// directed words; typed rows carry their own expected result
	row_t plan [N_ROWS] = '{
		'{"=",   1'b1, TYPED, '{8'h00, 1'b0, 1'b1}},
		'{8'h00, 1'b0, PRED,  NO_RES},
		'{8'hff, 1'b0, PRED,  NO_RES},
		'{"0",   1'b0, PRED,  NO_RES},
		'{"1",   1'b0, PRED,  NO_RES},
		'{"8",   1'b0, PRED,  NO_RES},
		'{"9",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b0, PRED,  NO_RES},
		'{"7",   1'b1, TYPED, '{8'hff, 1'b1, 1'b1}},
		'{"a",   1'b0, PRED,  NO_RES},
		'{"Z",   1'b0, PRED,  NO_RES},
		'{"z",   1'b0, PRED,  NO_RES},
		'{"2",   1'b0, PRED,  NO_RES},
		'{"A",   1'b0, PRED,  NO_RES},
		'{"@",   1'b0, PRED,  NO_RES},
		'{"{",   1'b0, PRED,  NO_RES},
		'{"3",   1'b0, PRED,  NO_RES},
		'{8'h80, 1'b1, TYPED, '{8'h00, 1'b0, 1'b1}},
		'{"z",   1'b1, TYPED, '{8'h00, 1'b0, 1'b1}}
	};

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	char_word_t char_word;
	logic       res_valid;
	logic       res_stall;
	res_word_t  res_word;

	logic [2:0] dec_pos;
	logic [7:0] dec_acc;
	res_word_t  expected_decodes [$];

	int  chars_sent;
	int  symbols_sent;
	int  bytes_seen;
	int  msgs_seen;
	int  mismatches;
	int  burst_left;
	bit  no_gaps;
	bit  long_hold_req;

	base32_decoder_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sym_t alphabet_index(input logic [7:0] c);
		sym_t       s;
		logic [7:0] u;
		u = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - CASE_FOLD : c;
		s.valid = 1'b1;
		s.value = '0;
		if (u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) begin
			s.value = 5'(u - CHAR_UPPER_A);
		end else if (u >= CHAR_TWO && u <= CHAR_SEVEN) begin
			s.value = 5'(u - CHAR_TWO) + DIGIT_BASE;
		end else begin
			s.valid = 1'b0;
		end
		return s;
	endfunction

	// packs one symbol MSB first; returns 1 when a result word is due
	function automatic bit decode_char(input char_word_t w, output res_word_t r);
		sym_t       s;
		logic [2:0] npos;
		logic [7:0] done_byte;
		bit         done;
		s = alphabet_index(w.in_char);
		done = 1'b0;
		done_byte = '0;
		r = NO_RES;
		if (s.valid) begin
			npos = dec_pos + SYM_ADVANCE;
			if (dec_pos <= POS_FILL) begin
				if (npos == 3'd0) begin
					done_byte = dec_acc | 8'(s.value);
					done = 1'b1;
					dec_acc = '0;
				end else begin
					dec_acc = dec_acc | 8'(8'(s.value) << (4'd8 - npos));
				end
			end else begin
				done_byte = dec_acc | 8'(8'(s.value) >> npos);
				done = 1'b1;
				dec_acc = 8'(8'(s.value) << (4'd8 - npos));
			end
			dec_pos = npos;
		end
		if (w.last_char) begin
			r.out_byte = done ? done_byte : 8'h00;
			r.byte_valid = done;
			r.end_of_message = 1'b1;
			dec_pos = '0;
			dec_acc = '0;
			return 1'b1;
		end
		if (done) begin
			r.out_byte = done_byte;
			r.byte_valid = 1'b1;
			r.end_of_message = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] random_symbol_char();
		int v;
		v = $urandom_range(0, 31);
		if (v < 26)
			return ($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v);
		return CHAR_TWO + 8'(v - 26);
	endfunction

	task automatic send_char(input char_word_t w, input logic typed, input res_word_t want);
		res_word_t r;
		sym_t      s;
		bit        got;
		int        gap;
		int        pick;
		char_valid <= 1'b1;
		char_word <= w;
		@(posedge clk);
		while (char_stall !== 1'b0) @(posedge clk);
		chars_sent++;
		s = alphabet_index(w.in_char);
		if (s.valid || w.last_char)
			symbols_sent++;
		got = decode_char(w, r);
		if (typed)
			expected_decodes.push_back(want);
		else if (got)
			expected_decodes.push_back(r);
		if (no_gaps) begin
			gap = 0;
		end else if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				burst_left = $urandom_range(30, 80);
				gap = 0;
			end else if (pick < 55) begin
				gap = 0;
			end else if (pick < 85) begin
				gap = $urandom_range(1, 3);
			end else if (pick < 97) begin
				gap = $urandom_range(4, 10);
			end else begin
				gap = $urandom_range(20, 40);
			end
		end
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		char_valid <= 1'b0;
		while (expected_decodes.size() != 0) @(posedge clk);
	endtask

	// receiver: random stalls, free stretches, and one long hold on request
	initial begin : res_side
		int hold_left;
		int free_left;
		int pick;
		hold_left = 0;
		free_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				free_left = 0;
			end
			if (hold_left == 0 && free_left == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					free_left = $urandom_range(1, 4);
				else if (pick < 60)
					free_left = $urandom_range(20, 60);
				else if (pick < 95)
					hold_left = $urandom_range(1, 3);
				else
					hold_left = $urandom_range(10, 30);
			end
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else begin
				res_stall <= 1'b0;
				free_left--;
			end
		end
	end

	always @(posedge clk) begin : res_check
		res_word_t want;
		int        idle;
		if (arst_n === 1'b1) begin
			if ((char_valid && char_stall === 1'b0) || (res_valid === 1'b1 && !res_stall))
				idle = 0;
			else
				idle++;
			if (idle >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("** base32_decoder_top: FAILED **");
				$finish;
			end
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				if (expected_decodes.size() == 0) begin
					$error("unexpected result word %h", res_word);
					mismatches++;
				end else begin
					want = expected_decodes.pop_front();
					if (res_word.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, res_word.out_byte);
						mismatches++;
					end
					if (res_word.byte_valid !== want.byte_valid) begin
						$error("byte_valid: expected %b, got %b",
							want.byte_valid, res_word.byte_valid);
						mismatches++;
					end
					if (res_word.end_of_message !== want.end_of_message) begin
						$error("end_of_message: expected %b, got %b",
							want.end_of_message, res_word.end_of_message);
						mismatches++;
					end
					bytes_seen += want.byte_valid;
					msgs_seen += want.end_of_message;
				end
			end
		end else begin
			idle = 0;
		end
	end

	initial begin : char_side
		logic [7:0] ch;
		int         len;
		int         pick;
		bit         held;
		bit         paused;
		chars_sent = 0;
		symbols_sent = 0;
		bytes_seen = 0;
		msgs_seen = 0;
		mismatches = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		long_hold_req = 1'b0;
		held = 1'b0;
		paused = 1'b0;
		dec_pos = '0;
		dec_acc = '0;
		arst_n <= 1'b0;
		char_valid <= 1'b0;
		char_word <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_char({plan[i].ch, plan[i].last_flag}, plan[i].typed, plan[i].want);

		while (chars_sent < N_ITEMS) begin
			if (!held && chars_sent >= N_ITEMS / 3) begin
				// back up the result side until the input stalls
				held = 1'b1;
				long_hold_req = 1'b1;
				no_gaps = 1'b1;
				repeat (30) send_char({random_symbol_char(), 1'b0}, PRED, NO_RES);
				no_gaps = 1'b0;
			end
			if (!paused && chars_sent >= 2 * N_ITEMS / 3) begin
				paused = 1'b1;
				wait_for_results();
			end
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
				for (int k = 0; k < len; k++) begin
					pick = $urandom_range(0, 19);
					if (pick < 17)
						ch = random_symbol_char();
					else if (pick < 19)
						ch = 8'($urandom_range(0, 255));
					else
						ch = SKIP_CHARS[$urandom_range(0, 4)];
					send_char({ch, 1'(k == len - 1)}, PRED, NO_RES);
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_char({8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0)},
						PRED, NO_RES);
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("%0d characters sent (%0d symbols or message ends), incl. a long result hold",
			chars_sent, symbols_sent);
		$display("%0d decoded bytes and %0d message ends checked, %0d mismatches",
			bytes_seen, msgs_seen, mismatches);
		if (mismatches == 0 && expected_decodes.size() == 0) begin
			$display("** base32_decoder_top: PASSED **");
		end else begin
			$display("** base32_decoder_top: FAILED **");
		end
		$finish;
	end

endmodule
